// ----- src/rc4_pkg.sv -----
`timescale 1ns / 1ps
// rc4_pkg: shared constants, types and sequencer states of the rc4 cipher unit
// no dependencies; imported by rc4_core and rc4_stream_cipher_unit

package rc4_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PERM_DEPTH    = 256;
  localparam int unsigned KEY_BYTES     = 16;
  localparam int unsigned MAX_KEY_BYTES = 16;
  localparam int unsigned KEY_LEN_W     = 5;
  localparam int unsigned KEY_IDX_W     = $clog2(KEY_BYTES);
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_ADDR_W    = 5;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KSA_RD_J,
    ST_KSA_WR_J,
    ST_KSA_WR_K,
    ST_GEN_RD_I,
    ST_GEN_RD_J,
    ST_GEN_WR_J,
    ST_GEN_WR_I,
    ST_GEN_OUT
  } rc4_state_e;

  typedef struct packed {
    logic              start;
    logic              restart;
    logic [BYTE_W-1:0] data;
    logic              res_ready;
  } rc4_req_t;

  typedef struct packed {
    logic              ready;
    logic              res_valid;
    logic [BYTE_W-1:0] res_byte;
  } rc4_rsp_t;

endpackage

// ----- src/rc4_ram.sv -----
`timescale 1ns / 1ps
// rc4_ram: generic one-write one-read synchronous ram with registered read data
// no dependencies

module rc4_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rc4_core.sv -----
`timescale 1ns / 1ps
// rc4_core: sequencer for key schedule and keystream generation on the permutation ram
// depends on rc4_pkg and rc4_ram

module rc4_core import rc4_pkg::*; #(
  parameter int unsigned MaxKeyBytes = MAX_KEY_BYTES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rc4_req_t                   req_i,
  input  logic [8*KEY_BYTES-1:0]     key_i,
  input  logic [KEY_LEN_W-1:0]       key_len_i,
  output rc4_rsp_t                   rsp_o
);

  localparam int unsigned AddrW = $clog2(PERM_DEPTH);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(PERM_DEPTH - 1);

  rc4_state_e state_q, state_d;
  logic [AddrW-1:0]     k_q, k_d;
  logic [KEY_IDX_W-1:0] kk_q, kk_d;
  logic [KEY_LEN_W-1:0] len_q, len_d;
  logic [AddrW-1:0]     i_q, i_d, j_q, j_d;
  logic [BYTE_W-1:0]    si_q, si_d, sj_q, sj_d, data_q, data_d;
  logic                 done_q, done_d, fwd_q, fwd_d;

  logic                 ram_we, ram_re;
  logic [AddrW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]    ram_wdata, ram_rdata;

  logic [KEY_LEN_W-1:0] len_clamped;
  logic [BYTE_W-1:0]    key_byte;
  logic [AddrW-1:0]     t_addr;
  logic [BYTE_W-1:0]    ks_byte;

  rc4_ram #(
    .Width (BYTE_W),
    .Depth (PERM_DEPTH)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // length saturates into 1..MaxKeyBytes
  always_comb begin
    len_clamped = key_len_i;
    if (key_len_i == '0) begin
      len_clamped = KEY_LEN_W'(1);
    end else if (key_len_i > KEY_LEN_W'(MaxKeyBytes)) begin
      len_clamped = KEY_LEN_W'(MaxKeyBytes);
    end
  end

  assign key_byte = key_i[kk_q*8 +: 8];
  assign t_addr   = AddrW'(si_q + sj_q);
  assign ks_byte  = fwd_q ? sj_q : ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    kk_q   <= kk_d;
    len_q  <= len_d;
    si_q   <= si_d;
    sj_q   <= sj_d;
    data_q <= data_d;
    fwd_q  <= fwd_d;
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    kk_d      = kk_q;
    len_d     = len_q;
    i_d       = i_q;
    j_d       = j_q;
    si_d      = si_q;
    sj_d      = sj_q;
    data_d    = data_q;
    done_d    = done_q;
    fwd_d     = fwd_q;
    ram_we    = 1'b0;
    ram_waddr = k_q;
    ram_wdata = sj_q;
    ram_re    = 1'b0;
    ram_raddr = k_q;
    rsp_o.ready     = 1'b0;
    rsp_o.res_valid = 1'b0;
    rsp_o.res_byte  = data_q ^ ks_byte;

    case (state_q)
      ST_IDLE: begin
        rsp_o.ready = 1'b1;
        if (req_i.start) begin
          data_d = req_i.data;
          if (req_i.restart || !done_q) begin
            k_d     = '0;
            len_d   = len_clamped;
            state_d = ST_INIT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = i_q + 1'b1;
            i_d       = i_q + 1'b1;
            state_d   = ST_GEN_RD_J;
          end
        end
      end
      // identity fill, one entry a cycle
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = BYTE_W'(k_q);
        k_d       = k_q + 1'b1;
        if (k_q == LastAddr) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          kk_d      = '0;
          j_d       = '0;
          state_d   = ST_KSA_RD_J;
        end
      end
      ST_KSA_RD_J: begin
        si_d      = ram_rdata;
        j_d       = AddrW'(j_q + ram_rdata + key_byte);
        ram_re    = 1'b1;
        ram_raddr = AddrW'(j_q + ram_rdata + key_byte);
        state_d   = ST_KSA_WR_J;
      end
      ST_KSA_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        sj_d      = ram_rdata;
        state_d   = ST_KSA_WR_K;
      end
      // write back S[k] and, unless k is the last entry, fetch S[k+1] in the same cycle
      ST_KSA_WR_K: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = sj_q;
        k_d       = k_q + 1'b1;
        if ((KEY_LEN_W'(kk_q) + 1'b1) == len_q) begin
          kk_d = '0;
        end else begin
          kk_d = kk_q + 1'b1;
        end
        if (k_q == LastAddr) begin
          i_d     = '0;
          j_d     = '0;
          done_d  = 1'b1;
          state_d = ST_GEN_RD_I;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = k_q + 1'b1;
          state_d   = ST_KSA_RD_J;
        end
      end
      ST_GEN_RD_I: begin
        ram_re    = 1'b1;
        ram_raddr = i_q + 1'b1;
        i_d       = i_q + 1'b1;
        state_d   = ST_GEN_RD_J;
      end
      ST_GEN_RD_J: begin
        si_d      = ram_rdata;
        j_d       = AddrW'(j_q + ram_rdata);
        ram_re    = 1'b1;
        ram_raddr = AddrW'(j_q + ram_rdata);
        state_d   = ST_GEN_WR_J;
      end
      ST_GEN_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        sj_d      = ram_rdata;
        state_d   = ST_GEN_WR_I;
      end
      // S[t] is read while S[i] is written; t == i takes the forwarded value
      ST_GEN_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = sj_q;
        ram_re    = 1'b1;
        ram_raddr = t_addr;
        fwd_d     = (t_addr == i_q);
        state_d   = ST_GEN_OUT;
      end
      ST_GEN_OUT: begin
        if (req_i.res_ready) begin
          rsp_o.res_valid = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/rc4_stream_cipher_unit.sv -----
`timescale 1ns / 1ps
// rc4_stream_cipher_unit: top level with apb key registers, stream ports and output register
// depends on rc4_pkg, rc4_core and rc4_ram

// usage:
//   s_axis carries one input word per byte: tdata is the byte to combine, tuser the
//   restart flag. m_axis returns one word per input word, tdata = byte xor keystream,
//   in order. encryption and decryption are the same operation.
//   key bytes and key length are set over the apb port (64-bit data, registers at
//   byte addresses 0, 8, 16) while the unit is idle; a new key is used at the next
//   restart or at the first word after reset.
// sequence:
//   a word without restart goes from acceptance through gen_rd_j, gen_wr_j, gen_wr_i
//   and gen_out, waiting there while the output register is full, before the next
//   word is accepted: the permutation ram has one read and one write port, and each
//   byte needs three reads and two writes through it. a word with restart, and the
//   first word after reset, first runs an identity fill of 256 entries, then 256 key
//   schedule steps through ksa_rd_j, ksa_wr_j and ksa_wr_k, and gen_rd_i to start.
// reset:
//   indices clear, the key registers return to zero with length 16, and the next
//   word runs the key schedule first; the ram contents are not cleared.
// stall:
//   the result sits in an output register; while it is not taken the core holds
//   its finished result and s_axis_tready_o stays low once the core is busy.

module rc4_stream_cipher_unit import rc4_pkg::*; #(
  parameter int unsigned MaxKeyBytes = MAX_KEY_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [BYTE_W-1:0]     s_axis_tdata_i,  // [7:0] data_byte
  input  logic                  s_axis_tuser_i,  // [0] restart
  // output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [BYTE_W-1:0]     m_axis_tdata_o,  // [7:0] out_byte
  // configuration
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [CFG_ADDR_W-1:0] paddr_i,
  input  logic [CFG_DATA_W-1:0] pwdata_i,
  output logic [CFG_DATA_W-1:0] prdata_o,
  output logic                  pready_o
);

  logic [CFG_DATA_W-1:0] key_low_q, key_high_q;
  logic [KEY_LEN_W-1:0]  key_len_q;
  logic                  cfg_wr;
  logic [1:0]            cfg_idx;

  logic                  out_valid_q;
  logic [BYTE_W-1:0]     out_byte_q;
  logic                  out_free;

  rc4_req_t core_req;
  rc4_rsp_t core_rsp;

  // apb registers, write on the access phase
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign cfg_idx  = paddr_i[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= KEY_LEN_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY_LOW:  key_low_q  <= pwdata_i;
        REG_KEY_HIGH: key_high_q <= pwdata_i;
        REG_KEY_LEN:  key_len_q  <= pwdata_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KEY_LOW:  prdata_o = key_low_q;
      REG_KEY_HIGH: prdata_o = key_high_q;
      REG_KEY_LEN:  prdata_o = CFG_DATA_W'(key_len_q);
      default:      prdata_o = '0;
    endcase
  end

  // core hookup
  assign s_axis_tready_o    = core_rsp.ready;
  assign core_req.start     = s_axis_tvalid_i && core_rsp.ready;
  assign core_req.restart   = s_axis_tuser_i;
  assign core_req.data      = s_axis_tdata_i;
  assign core_req.res_ready = out_free;

  rc4_core #(
    .MaxKeyBytes (MaxKeyBytes)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (core_req),
    .key_i     ({key_high_q, key_low_q}),
    .key_len_i (key_len_q),
    .rsp_o     (core_rsp)
  );

  // output register; loads whenever it is empty or being drained
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= core_rsp.res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && core_rsp.res_valid) begin
      out_byte_q <= core_rsp.res_byte;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;

`ifndef SYNTH
  // the core only hands over a result when the output register can take it
  a_res_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_rsp.res_valid |-> out_free)
    else $error("result offered while output register is full");

  // an accepted word makes the unit busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted on consecutive cycles");

  // a handed-over result shows on the output in the next cycle
  a_res_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_rsp.res_valid |=> m_axis_tvalid_o)
    else $error("result lost between core and output register");

  // the core is never idle and holding a result at once
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_rsp.ready |-> !core_rsp.res_valid)
    else $error("core idle while presenting a result");
`endif

endmodule
